// ===== rtl/tft_pkg.sv =====
// Shared types and constants for the tile freshness table.
// Used by tft_ctrl, tft_datapath and tile_freshness_table; no dependencies.
package tft_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int TABLE_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int GRID_W      = 7;
  localparam int EPOCH_W     = 32;
  localparam int LEVEL_W     = 8;
  localparam int POS_W       = 8;

  localparam logic [EPOCH_W-1:0] EPOCH_GRACE = EPOCH_W'(3);
  localparam logic signed [LEVEL_W-1:0] LEVEL_UNFILLED = '1;

  localparam logic [GRID_W-1:0] MAX_COLUMNS_G = GRID_W'(MAX_COLUMNS);
  localparam logic [GRID_W-1:0] MAX_ROWS_G    = GRID_W'(MAX_ROWS);

  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    OP_UPDATE    = 2'd0,
    OP_QUERY     = 2'd1,
    OP_RESET_ALL = 2'd2
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [POS_W-1:0]   tile_col;
    logic signed [POS_W-1:0]   tile_row;
    logic [EPOCH_W-1:0]        render_epoch;
    logic signed [LEVEL_W-1:0] detail_level;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic               needs_content;
    logic [COUNT_W-1:0] unfilled_total;
  } result_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]        epoch;
    logic signed [LEVEL_W-1:0] level;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear_start;
    logic clear_step;
    logic resolve;
    logic finish_wipe;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

  function automatic logic [GRID_W-1:0] sat_dim(input logic [GRID_W-1:0] v,
                                                input logic [GRID_W-1:0] lim);
    sat_dim = (v > lim) ? lim : v;
  endfunction

endpackage

// ===== rtl/tft_ctrl.sv =====
// Sequencer for the tile freshness table: lookup, write-back and clearing sweep.
// Depends on tft_pkg; drives tft_datapath through cmd_t / status_t.
module tft_ctrl
  import tft_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  op_t     op,
  input  logic    cfg_valid,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   wipe_result, wipe_result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      wipe_result <= 1'b0;
    end else begin
      state       <= state_next;
      wipe_result <= wipe_result_next;
    end
  end

  always_comb begin
    state_next       = state;
    wipe_result_next = wipe_result;
    cmd              = '0;
    case (state)
      ST_IDLE: begin
        if (cfg_valid) begin
          cmd.clear_start  = 1'b1;
          wipe_result_next = 1'b0;
          state_next       = ST_CLEAR;
        end else if (start) begin
          cmd.capture = 1'b1;
          if (op == OP_RESET_ALL) begin
            cmd.clear_start  = 1'b1;
            wipe_result_next = 1'b1;
            state_next       = ST_CLEAR;
          end else begin
            state_next = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        cmd.resolve = 1'b1;
        state_next  = ST_IDLE;
        if (cfg_valid) begin
          cmd.clear_start  = 1'b1;
          wipe_result_next = 1'b0;
          state_next       = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (cfg_valid) begin
          cmd.clear_start  = 1'b1;
          wipe_result_next = 1'b0;
        end else begin
          cmd.clear_step = 1'b1;
          if (status.clear_last) begin
            cmd.finish_wipe  = wipe_result;
            wipe_result_next = 1'b0;
            state_next       = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE) || cfg_valid;

`ifndef NO_ASSERTIONS
  a_lookup_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture && op != OP_RESET_ALL) |=> state == ST_LOOKUP)
    else $error("captured request did not enter lookup");

  a_clear_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_start |=> (state == ST_CLEAR && !cmd.finish_wipe))
    else $error("clear sweep did not start from the top");
`endif

endmodule

// ===== rtl/tft_datapath.sv =====
// Datapath: grid registers, entry memory, freshness decision, unfilled counter,
// result register. Depends on tft_pkg; controlled by tft_ctrl.
module tft_datapath
  import tft_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  req_t               req,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [GRID_W-1:0]  cfg_data,
  output status_t            status,
  output logic               done,
  output result_t            result
);

  logic [GRID_W-1:0]  grid_columns, grid_rows;
  logic [GRID_W-1:0]  cols_next, rows_next;
  logic [GRID_W-1:0]  eff_cols, eff_rows;
  logic [COUNT_W-1:0] unfilled, unfilled_next;
  logic [ADDR_W-1:0]  clear_addr;
  logic [ADDR_W-1:0]  addr, addr_q;
  logic               in_range, in_range_q;
  req_t               req_q;
  entry_t             rdata;
  entry_t             mem [TABLE_DEPTH];

  logic [2*GRID_W-1:0]        grid_area;
  logic [POS_W+GRID_W-1:0]    row_base;
  logic                       mem_we;
  logic [ADDR_W-1:0]          waddr;
  entry_t                     wdata;
  logic [EPOCH_W-1:0]         epoch_gap;
  logic                       old_filled, new_filled, finer, older, same;
  logic                       grace_ok, fresh, upd_write;
  result_t                    result_next;

  // grid registers; any write clears the table
  always_comb begin
    cols_next = grid_columns;
    rows_next = grid_rows;
    if (cfg_valid) begin
      if (cfg_index == REG_GRID_COLUMNS) begin
        cols_next = cfg_data;
      end else begin
        rows_next = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= '0;
      grid_rows    <= '0;
    end else begin
      grid_columns <= cols_next;
      grid_rows    <= rows_next;
    end
  end

  assign eff_cols  = sat_dim(grid_columns, MAX_COLUMNS_G);
  assign eff_rows  = sat_dim(grid_rows, MAX_ROWS_G);
  assign grid_area = sat_dim(cols_next, MAX_COLUMNS_G) * sat_dim(rows_next, MAX_ROWS_G);

  // address of the offered position
  assign in_range = !req.tile_col[POS_W-1] && !req.tile_row[POS_W-1] &&
                    ($unsigned(req.tile_col) < {1'b0, eff_cols}) &&
                    ($unsigned(req.tile_row) < {1'b0, eff_rows});
  assign row_base = $unsigned(req.tile_row) * eff_cols;
  assign addr     = ADDR_W'(row_base + (POS_W+GRID_W)'($unsigned(req.tile_col)));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q      <= req;
      addr_q     <= addr;
      in_range_q <= in_range;
    end
  end

  // freshness decision
  assign old_filled = !rdata.level[LEVEL_W-1];
  assign new_filled = !req_q.detail_level[LEVEL_W-1];
  assign finer      = req_q.detail_level < rdata.level;
  assign older      = req_q.render_epoch < rdata.epoch;
  assign same       = req_q.render_epoch == rdata.epoch;
  assign epoch_gap  = rdata.epoch - req_q.render_epoch;
  assign grace_ok   = (epoch_gap <= EPOCH_GRACE) && old_filled && new_filled && finer;
  assign fresh      = (!older || grace_ok) && !(same && old_filled && !finer);
  assign upd_write  = cmd.resolve && req_q.op == OP_UPDATE && in_range_q && fresh;

  // entry memory
  assign mem_we      = cmd.clear_step || upd_write;
  assign waddr       = cmd.clear_step ? clear_addr : addr_q;
  assign wdata.epoch = cmd.clear_step ? '0 : req_q.render_epoch;
  assign wdata.level = cmd.clear_step ? LEVEL_UNFILLED : req_q.detail_level;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.capture) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  assign status.clear_last = clear_addr == ADDR_W'(TABLE_DEPTH - 1);

  // unfilled counter
  always_comb begin
    unfilled_next = unfilled;
    if (cmd.clear_start) begin
      unfilled_next = COUNT_W'(grid_area);
    end else if (upd_write && !old_filled && new_filled && unfilled != '0) begin
      unfilled_next = unfilled - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unfilled <= '0;
    end else begin
      unfilled <= unfilled_next;
    end
  end

  // result register
  always_comb begin
    result_next.accepted       = upd_write || cmd.finish_wipe;
    result_next.needs_content  = cmd.resolve && req_q.op == OP_QUERY &&
                                 in_range_q && !old_filled;
    result_next.unfilled_total = unfilled_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.resolve || cmd.finish_wipe;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve || cmd.finish_wipe) begin
      result <= result_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, unfilled} <= ({{GRID_W{1'b0}}, eff_cols} * {{GRID_W{1'b0}}, eff_rows}))
    else $error("unfilled counter above grid area");

  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(done))
    else $error("result strobes back to back");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.resolve || cmd.finish_wipe))
    else $error("result strobe without a finished request");
`endif

endmodule

// ===== rtl/tile_freshness_table.sv =====
// Top level of the tile freshness table. Depends on tft_pkg, tft_ctrl, tft_datapath.
// Update, query and unknown ops: captured, resolved in the lookup state, then done strobes
// with the registered result; busy holds off the next request until lookup is left, as the
// entry memory is read at capture and written back in lookup. Reset-all: the clearing sweep
// of all TABLE_DEPTH entries, one per cycle. After rst and after every grid register write
// busy stays high for a clearing sweep; registers read 0 after rst. Results cannot be stalled.
module tile_freshness_table
  import tft_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [GRID_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (req.op),
    .cfg_valid (cfg_valid),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  tft_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== verif/tile_freshness_table_tb.sv =====
// Self-checking testbench for tile_freshness_table: directed and random requests,
// grid resizes, and a transaction-level predictor of the tile table. Depends on tft_pkg
// and the tile_freshness_table RTL.
module tile_freshness_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tft_pkg::*;

  localparam op_t OP_UNDEFINED = op_t'(2'd3);

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  req_t              req;
  logic              done;
  result_t           result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [GRID_W-1:0] cfg_data;

  logic [EPOCH_W-1:0]        tile_epoch [TABLE_DEPTH];
  logic signed [LEVEL_W-1:0] tile_level [TABLE_DEPTH];
  int                        unfilled_tiles;
  int                        grid_cols;
  int                        grid_rows;
  result_t                   expected_results [$];
  int                        errors = 0;
  bit                        no_gaps = 1'b0;

  tile_freshness_table DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_dim(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic void wipe_tiles();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tile_epoch[i] = '0;
      tile_level[i] = LEVEL_UNFILLED;
    end
    unfilled_tiles = eff_dim(grid_cols, MAX_COLUMNS) * eff_dim(grid_rows, MAX_ROWS);
  endfunction

  function automatic result_t predict_tile(input req_t r);
    result_t            res;
    int                 cols;
    int                 rows;
    int                 col;
    int                 row;
    int                 idx;
    int                 old_level;
    int                 new_level;
    logic [EPOCH_W-1:0] old_epoch;
    bit                 in_grid;
    bit                 ok;
    res       = '0;
    cols      = eff_dim(grid_cols, MAX_COLUMNS);
    rows      = eff_dim(grid_rows, MAX_ROWS);
    col       = $signed(r.tile_col);
    row       = $signed(r.tile_row);
    new_level = $signed(r.detail_level);
    in_grid   = (col >= 0) && (row >= 0) && (col < cols) && (row < rows);
    idx       = in_grid ? row * cols + col : 0;
    case (r.op)
      OP_UPDATE: begin
        if (in_grid) begin
          old_epoch = tile_epoch[idx];
          old_level = tile_level[idx];
          ok = 1'b1;
          if (r.render_epoch < old_epoch)
            ok = ((old_epoch - r.render_epoch) <= EPOCH_GRACE) && (old_level >= 0) &&
                 (new_level >= 0) && (new_level < old_level);
          if (ok && r.render_epoch == old_epoch && old_level >= 0 && new_level >= old_level)
            ok = 1'b0;
          if (ok) begin
            tile_epoch[idx] = r.render_epoch;
            tile_level[idx] = r.detail_level;
            if (old_level < 0 && new_level >= 0 && unfilled_tiles > 0)
              unfilled_tiles--;
            res.accepted = 1'b1;
          end
        end
      end
      OP_QUERY: begin
        res.needs_content = in_grid && (tile_level[idx] < 0);
      end
      OP_RESET_ALL: begin
        wipe_tiles();
        res.accepted = 1'b1;
      end
      default: ;
    endcase
    res.unfilled_total = COUNT_W'(unfilled_tiles);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t make_request(input op_t op, input int col, input int row,
                                        input logic [EPOCH_W-1:0] epoch, input int level);
    req_t r;
    r.op           = op;
    r.tile_col     = POS_W'(col);
    r.tile_row     = POS_W'(row);
    r.render_epoch = epoch;
    r.detail_level = LEVEL_W'(level);
    return r;
  endfunction

  // Mostly in-grid requests near the stored epoch so the freshness rules get exercised.
  function automatic req_t random_request();
    req_t               r;
    int                 cols;
    int                 rows;
    int                 pick;
    int                 col;
    int                 row;
    logic [EPOCH_W-1:0] base;
    cols = eff_dim(grid_cols, MAX_COLUMNS);
    rows = eff_dim(grid_rows, MAX_ROWS);
    pick = $urandom_range(0, 999);
    if (pick < 10)       r.op = OP_RESET_ALL;
    else if (pick < 40)  r.op = OP_UNDEFINED;
    else if (pick < 340) r.op = OP_QUERY;
    else                 r.op = OP_UPDATE;
    if (cols > 0 && rows > 0 && $urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 1)) begin
        col = $urandom_range(0, ((cols < 4) ? cols : 4) - 1);
        row = $urandom_range(0, ((rows < 4) ? rows : 4) - 1);
      end else begin
        col = $urandom_range(0, cols - 1);
        row = $urandom_range(0, rows - 1);
      end
      base = tile_epoch[row * cols + col];
    end else begin
      col  = $urandom_range(0, 255);
      row  = $urandom_range(0, 255);
      base = $urandom();
    end
    r.tile_col = POS_W'(col);
    r.tile_row = POS_W'(row);
    pick = $urandom_range(0, 99);
    if (pick < 70)      r.render_epoch = base + EPOCH_W'($urandom_range(0, 8)) - EPOCH_W'(5);
    else if (pick < 90) r.render_epoch = $urandom();
    else                r.render_epoch = $urandom_range(0, 1) ? '0 : '1;
    pick = $urandom_range(0, 99);
    if (pick < 75)      r.detail_level = LEVEL_W'($urandom_range(0, 15));
    else if (pick < 88) r.detail_level = LEVEL_UNFILLED;
    else                r.detail_level = LEVEL_W'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    expected_results = {expected_results, predict_tile(r)};
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= GRID_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GRID_COLUMNS) grid_cols = value;
    else                         grid_rows = value;
    wipe_tiles();
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  task automatic set_grid(input int cols, input int rows);
    wait_drained();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_GRID_COLUMNS, cols);
      write_reg(REG_GRID_ROWS, rows);
    end else begin
      write_reg(REG_GRID_ROWS, rows);
      write_reg(REG_GRID_COLUMNS, cols);
    end
  endtask

  task automatic test_empty_grid();
    send_request(make_request(OP_UPDATE, 0, 0, 1, 0));
    send_request(make_request(OP_QUERY, 0, 0, 0, 0));
  endtask

  task automatic test_update_rules();
    set_grid(127, 64);
    send_request(make_request(OP_UPDATE, 0, 0, 10, 5));
    send_request(make_request(OP_UPDATE, 0, 0, 10, 5));
    send_request(make_request(OP_UPDATE, 0, 0, 10, 4));
    send_request(make_request(OP_UPDATE, 0, 0, 8, 3));
    send_request(make_request(OP_UPDATE, 0, 0, 4, 0));
    send_request(make_request(OP_UPDATE, 0, 0, 5, 2));
    send_request(make_request(OP_UPDATE, 0, 0, 3, 2));
    send_request(make_request(OP_UPDATE, 0, 0, '1, 127));
    send_request(make_request(OP_UPDATE, 0, 0, '1, -1));
    send_request(make_request(OP_QUERY, 0, 0, 0, 0));
    send_request(make_request(OP_UPDATE, 63, 63, 0, 0));
    send_request(make_request(OP_UPDATE, 63, 63, 0, -128));
    send_request(make_request(OP_UPDATE, 64, 0, 20, 0));
    send_request(make_request(OP_UPDATE, -128, 5, 20, 0));
    send_request(make_request(OP_UPDATE, 0, -1, 20, 0));
    send_request(make_request(OP_QUERY, -1, -1, 0, 0));
    send_request(make_request(OP_QUERY, 5, 5, 0, 0));
    send_request(make_request(OP_UNDEFINED, 127, -128, '1, 127));
    send_request(make_request(OP_RESET_ALL, 0, 0, 0, 0));
    send_request(make_request(OP_QUERY, 0, 0, 0, 0));
  endtask

  // Unfilled stores leave the count low, so a later fill must saturate at zero.
  task automatic test_counter_floor();
    set_grid(1, 1);
    send_request(make_request(OP_UPDATE, 0, 0, 1, 1));
    send_request(make_request(OP_UPDATE, 0, 0, 2, -1));
    send_request(make_request(OP_QUERY, 0, 0, 0, 0));
    send_request(make_request(OP_UPDATE, 0, 0, 3, 0));
  endtask

  task automatic test_random_traffic();
    int cols_list [12] = '{1, 2, 0, 5, 8, 7, 64, 127, 65, 3, 16, 0};
    int rows_list [12] = '{1, 3, 5, 4, 8, 0, 64, 127, 2, 100, 1, 0};
    for (int p = 0; p < 12; p++) begin
      if (p == 11) set_grid($urandom_range(0, 127), $urandom_range(0, 127));
      else         set_grid(cols_list[p], rows_list[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (160) send_request(random_request());
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: %p", $time, result);
      end else begin
        want = expected_results.pop_front();
        if (result.accepted !== want.accepted) begin
          errors++;
          $display("%0t: accepted expected %0b actual %0b", $time, want.accepted,
                   result.accepted);
        end
        if (result.needs_content !== want.needs_content) begin
          errors++;
          $display("%0t: needs_content expected %0b actual %0b", $time, want.needs_content,
                   result.needs_content);
        end
        if (result.unfilled_total !== want.unfilled_total) begin
          errors++;
          $display("%0t: unfilled_total expected %0d actual %0d", $time,
                   want.unfilled_total, result.unfilled_total);
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_GRID_COLUMNS;
    cfg_data  <= '0;
    grid_cols = 0;
    grid_rows = 0;
    wipe_tiles();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_grid();
    test_update_rules();
    test_counter_floor();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
